FILE: hdl/master_joint_feedback_command_top_defines.svh
// Assertion macros for the master joint feedback command block.
// Used by master_joint_feedback_command_top; expects clk_i and rst_ni in scope.
`ifndef MASTER_JOINT_FEEDBACK_COMMAND_TOP_DEFINES_SVH
`define MASTER_JOINT_FEEDBACK_COMMAND_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MJFC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MJFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mjfc_pkg.sv
// Shared types, constants and saturating helpers for the joint feedback command block.
// No dependencies.
`default_nettype none

package mjfc_pkg;

  localparam int unsigned VALUE_WIDTH       = 32;
  localparam int unsigned PROD_WIDTH        = 2 * VALUE_WIDTH;
  localparam int unsigned DEF_FRACTION_BITS = 16;
  localparam int unsigned NUM_STAGES        = 7;
  localparam int unsigned APB_DATA_WIDTH    = 32;
  localparam int unsigned APB_ADDR_WIDTH    = 5;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic        [VALUE_WIDTH-2:0] mag_t;
  typedef logic signed [VALUE_WIDTH:0]   value_ext_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [PROD_WIDTH:0]    prod_ext_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    CTRL_HOLD   = 2'd0,
    CTRL_MIT    = 2'd1,
    CTRL_EFFORT = 2'd2
  } ctrl_mode_e;

  typedef enum logic [1:0] {
    FB_NONE   = 2'd0,
    FB_POS    = 2'd1,
    FB_EFFORT = 2'd2
  } fb_mode_e;

  typedef enum logic [2:0] {
    REG_CONTROL_MODE     = 3'd0,
    REG_FEEDBACK_MODE    = 3'd1,
    REG_POSITION_GAIN    = 3'd2,
    REG_DEAD_ZONE_WIDTH  = 3'd3,
    REG_CORRECTION_LIMIT = 3'd4,
    REG_STIFFNESS_GAIN   = 3'd5,
    REG_EFFORT_FB_GAIN   = 3'd6,
    REG_EFFORT_LIMIT     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    ctrl_mode_e control_mode;
    fb_mode_e   feedback_mode;
    value_t     position_gain;
    mag_t       dead_zone_width;
    mag_t       correction_limit;
    value_t     stiffness_gain;
    value_t     effort_feedback_gain;
    mag_t       effort_limit;
  } cfg_t;

  typedef struct packed {
    value_t measured_position;
    value_t reference_position;
    value_t external_torque_ref;
    value_t gravity_torque;
  } in_item_t;

  typedef struct packed {
    value_t position_command;
    value_t position_correction;
    value_t impedance_torque;
    value_t torque_command;
  } out_item_t;

  // Saturate a value with one guard bit back to the value range.
  function automatic value_t sat_ext(value_ext_t x);
    if (x[VALUE_WIDTH] != x[VALUE_WIDTH-1]) begin
      return x[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
    end
    return x[VALUE_WIDTH-1:0];
  endfunction

  function automatic value_t sat_add(value_t a, value_t b);
    value_ext_t sum;
    sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    return sat_ext(sum);
  endfunction

  // Saturate a scaled product back to the value range.
  function automatic value_t sat_prod(prod_ext_t x);
    logic [PROD_WIDTH-VALUE_WIDTH+1:0] top;
    top = x[PROD_WIDTH:VALUE_WIDTH-1];
    if (top == '0 || top == '1) begin
      return x[VALUE_WIDTH-1:0];
    end
    return x[PROD_WIDTH] ? VALUE_MIN : VALUE_MAX;
  endfunction

  // Symmetric clamp to [-lim, +lim].
  function automatic value_t limit_sym(value_t v, mag_t lim);
    value_t lim_pos;
    value_t lim_neg;
    lim_pos = {1'b0, lim};
    lim_neg = -lim_pos;
    if (v > lim_pos) begin
      return lim_pos;
    end else if (v < lim_neg) begin
      return lim_neg;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/master_joint_feedback_command_top.sv
// Master-side teleoperation command for one joint (top level; uses mjfc_pkg, mjfc_datapath
// and the assertion macros header). Each input transaction carries one Q16.16 joint sample
// (measured and reference position, external torque reference, gravity torque) and yields
// exactly one output transaction (position command, position correction, impedance torque,
// torque command). The position error goes through a dead zone, a symmetric clamp and a
// negated gain; the control and feedback modes route that correction into the position
// command or, through the stiffness, into the torque command, or instead feed back a
// clamped external torque through a negated gain. Products floor after the fraction shift
// and every result saturates to 32 bits. Throughput is one transaction per clock while the
// output is not stalled; the result passes through the seven register stages (error, dead
// zone, gain multiply, scale, stiffness multiply, scale, final add) before it leaves.
// Every
// stage holds its own valid bit and advances whenever it is empty or the stage after it
// moves, so bubbles close up and a stalled output still lets upstream stages fill.
// Registers sit on an APB port at byte address 4*index: 0 control_mode, 1 feedback_mode,
// 2 position_gain, 3 dead_zone_width, 4 correction_limit, 5 stiffness_gain,
// 6 effort_feedback_gain, 7 effort_limit; all reset to zero. Write them only while the
// pipeline is empty.
`default_nettype none
`include "master_joint_feedback_command_top_defines.svh"

module master_joint_feedback_command_top import mjfc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // sample channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire in_item_t                  in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output out_item_t                      out_data_o,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic      [APB_DATA_WIDTH-1:0] prdata,
  output logic                           pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t     cfg_q, cfg_d;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_WIDTH-1:2]);

  // Update the addressed register on the access phase of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_CONTROL_MODE:     cfg_d.control_mode         = ctrl_mode_e'(pwdata[1:0]);
        REG_FEEDBACK_MODE:    cfg_d.feedback_mode        = fb_mode_e'(pwdata[1:0]);
        REG_POSITION_GAIN:    cfg_d.position_gain        = pwdata[VALUE_WIDTH-1:0];
        REG_DEAD_ZONE_WIDTH:  cfg_d.dead_zone_width      = pwdata[VALUE_WIDTH-2:0];
        REG_CORRECTION_LIMIT: cfg_d.correction_limit     = pwdata[VALUE_WIDTH-2:0];
        REG_STIFFNESS_GAIN:   cfg_d.stiffness_gain       = pwdata[VALUE_WIDTH-1:0];
        REG_EFFORT_FB_GAIN:   cfg_d.effort_feedback_gain = pwdata[VALUE_WIDTH-1:0];
        REG_EFFORT_LIMIT:     cfg_d.effort_limit         = pwdata[VALUE_WIDTH-2:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back, zero-extended.
  always_comb begin
    case (cfg_idx)
      REG_CONTROL_MODE:     prdata = {{(APB_DATA_WIDTH-2){1'b0}}, cfg_q.control_mode};
      REG_FEEDBACK_MODE:    prdata = {{(APB_DATA_WIDTH-2){1'b0}}, cfg_q.feedback_mode};
      REG_POSITION_GAIN:    prdata = cfg_q.position_gain;
      REG_DEAD_ZONE_WIDTH:  prdata = {1'b0, cfg_q.dead_zone_width};
      REG_CORRECTION_LIMIT: prdata = {1'b0, cfg_q.correction_limit};
      REG_STIFFNESS_GAIN:   prdata = cfg_q.stiffness_gain;
      REG_EFFORT_FB_GAIN:   prdata = cfg_q.effort_feedback_gain;
      REG_EFFORT_LIMIT:     prdata = {1'b0, cfg_q.effort_limit};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, per-stage advance
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] stage_en;
  logic                  in_acc, out_acc;

  // A stage advances when it is empty or its successor advances; the last
  // stage advances when empty or when the consumer takes the transaction.
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  // Shift valid bits along with the data; hold a stage that cannot advance.
  always_comb begin
    valid_d[0] = stage_en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = stage_en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  mjfc_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic pipe_full_stall;
  int   occupancy;
  int   occ_next;

  assign pipe_full_stall = (&valid_q) && !out_ready_i;
  assign occupancy       = $countones(valid_q);
  assign occ_next        = occupancy + int'(in_acc) - int'(out_acc);

  // Input back-pressure only when every stage is full and the output is stalled.
  `MJFC_ASSERT_ALWAYS(a_ready_when_room, in_ready_o == !pipe_full_stall, "input stalled with room")
  // Occupancy tracks accepted inputs minus delivered outputs.
  `MJFC_ASSERT_IMP(a_occupancy, $past(rst_ni), occupancy == $past(occ_next), "pipeline count off")

endmodule

`default_nettype wire

FILE: hdl/mjfc_datapath.sv
// Seven-stage datapath for the joint feedback command: stage registers and arithmetic.
// Depends on mjfc_pkg; stage enables and configuration come from the top level.
`default_nettype none

module mjfc_datapath import mjfc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic [NUM_STAGES-1:0] stage_en_i,
  input  wire cfg_t                  cfg_i,
  input  wire in_item_t              in_data_i,
  output out_item_t                  out_data_o
);

  // Stage 1: position error and clamped external torque.
  value_t     s1_q_q, s1_tg_q, s1_err_q, s1_tl_q;
  value_ext_t s1_diff;

  assign s1_diff = {in_data_i.measured_position[VALUE_WIDTH-1], in_data_i.measured_position}
                 - {in_data_i.reference_position[VALUE_WIDTH-1],
                    in_data_i.reference_position};

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      s1_q_q   <= in_data_i.measured_position;
      s1_tg_q  <= in_data_i.gravity_torque;
      s1_err_q <= sat_ext(s1_diff);
      s1_tl_q  <= limit_sym(in_data_i.external_torque_ref, cfg_i.effort_limit);
    end
  end

  // Stage 2: dead zone, then clamp.
  value_t     s2_q_q, s2_tg_q, s2_d_q, s2_tl_q;
  value_ext_t s2_err_ext, s2_dz_pos, s2_dz_neg, s2_dz_val;

  always_comb begin
    s2_err_ext = {s1_err_q[VALUE_WIDTH-1], s1_err_q};
    s2_dz_pos  = {2'b00, cfg_i.dead_zone_width};
    s2_dz_neg  = -s2_dz_pos;
    if (s2_err_ext > s2_dz_pos) begin
      s2_dz_val = s2_err_ext - s2_dz_pos;
    end else if (s2_err_ext < s2_dz_neg) begin
      s2_dz_val = s2_err_ext + s2_dz_pos;
    end else begin
      s2_dz_val = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      s2_q_q  <= s1_q_q;
      s2_tg_q <= s1_tg_q;
      s2_d_q  <= limit_sym(s2_dz_val[VALUE_WIDTH-1:0], cfg_i.correction_limit);
      s2_tl_q <= s1_tl_q;
    end
  end

  // Stage 3: gain products.
  value_t s3_q_q, s3_tg_q;
  prod_t  s3_pp_q, s3_pe_q;
  prod_t  s3_pp_d, s3_pe_d;

  assign s3_pp_d = s2_d_q * cfg_i.position_gain;
  assign s3_pe_d = s2_tl_q * cfg_i.effort_feedback_gain;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      s3_q_q  <= s2_q_q;
      s3_tg_q <= s2_tg_q;
      s3_pp_q <= s3_pp_d;
      s3_pe_q <= s3_pe_d;
    end
  end

  // Stage 4: negate, floor-scale and saturate both products; the correction is zero unless the feedback mode is FB_POS.
  value_t    s4_q_q, s4_tg_q, s4_corr_q, s4_tfb_q;
  prod_ext_t s4_pp_neg, s4_pe_neg, s4_pp_scl, s4_pe_scl;
  value_t    s4_corr_d;

  always_comb begin
    s4_pp_neg = -{s3_pp_q[PROD_WIDTH-1], s3_pp_q};
    s4_pe_neg = -{s3_pe_q[PROD_WIDTH-1], s3_pe_q};
    s4_pp_scl = s4_pp_neg >>> FRACTION_BITS;
    s4_pe_scl = s4_pe_neg >>> FRACTION_BITS;
    s4_corr_d = (cfg_i.feedback_mode == FB_POS) ? sat_prod(s4_pp_scl) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      s4_q_q    <= s3_q_q;
      s4_tg_q   <= s3_tg_q;
      s4_corr_q <= s4_corr_d;
      s4_tfb_q  <= sat_prod(s4_pe_scl);
    end
  end

  // Stage 5: position command and stiffness product.
  value_t s5_qcmd_q, s5_tg_q, s5_corr_q, s5_tfb_q;
  prod_t  s5_pk_q;
  prod_t  s5_pk_d;
  value_t s5_qcmd_d;

  assign s5_pk_d = s4_corr_q * cfg_i.stiffness_gain;

  always_comb begin
    if (cfg_i.control_mode == CTRL_MIT && cfg_i.feedback_mode == FB_POS) begin
      s5_qcmd_d = sat_add(s4_q_q, s4_corr_q);
    end else begin
      s5_qcmd_d = s4_q_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      s5_qcmd_q <= s5_qcmd_d;
      s5_tg_q   <= s4_tg_q;
      s5_corr_q <= s4_corr_q;
      s5_tfb_q  <= s4_tfb_q;
      s5_pk_q   <= s5_pk_d;
    end
  end

  // Stage 6: impedance torque.
  value_t    s6_qcmd_q, s6_tg_q, s6_corr_q, s6_tfb_q, s6_timp_q;
  prod_ext_t s6_pk_scl;
  value_t    s6_timp_d;

  always_comb begin
    s6_pk_scl = $signed({s5_pk_q[PROD_WIDTH-1], s5_pk_q}) >>> FRACTION_BITS;
    if (cfg_i.control_mode == CTRL_EFFORT && cfg_i.feedback_mode == FB_POS) begin
      s6_timp_d = sat_prod(s6_pk_scl);
    end else begin
      s6_timp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[5]) begin
      s6_qcmd_q <= s5_qcmd_q;
      s6_tg_q   <= s5_tg_q;
      s6_corr_q <= s5_corr_q;
      s6_tfb_q  <= s5_tfb_q;
      s6_timp_q <= s6_timp_d;
    end
  end

  // Stage 7: torque command into the output register.
  out_item_t s7_out_q;
  value_t    s7_tcmd_d;

  always_comb begin
    case (cfg_i.control_mode)
      CTRL_EFFORT: begin
        case (cfg_i.feedback_mode)
          FB_POS:    s7_tcmd_d = sat_add(s6_timp_q, s6_tg_q);
          FB_EFFORT: s7_tcmd_d = sat_add(s6_tfb_q, s6_tg_q);
          default:   s7_tcmd_d = s6_tg_q;
        endcase
      end
      default: s7_tcmd_d = s6_tg_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[6]) begin
      s7_out_q.position_command    <= s6_qcmd_q;
      s7_out_q.position_correction <= s6_corr_q;
      s7_out_q.impedance_torque    <= s6_timp_q;
      s7_out_q.torque_command      <= s7_tcmd_d;
    end
  end

  assign out_data_o = s7_out_q;

endmodule

`default_nettype wire
